>>> design/les_pkg.sv
// les_pkg: shared types, constants and register codes for the line edge steering error block
// used by every file of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package les_pkg;

   // parameter defaults
   localparam int PIXELS_DEF      = 128;
   localparam int SAMPLE_BITS_DEF = 10;

   // fixed field widths
   localparam int POS_BITS      = 8;
   localparam int DB_BITS       = 10;
   localparam int LIM_BITS      = 7;
   localparam int ERR_BITS      = 8;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 10;

   localparam int ERR_MAX = 127;
   localparam int ERR_MIN = -128;

   // mapping arithmetic: (x - base) * (1 - e) over a small signed divisor
   localparam int NUM_BITS  = 17;
   localparam int MAG_BITS  = 16;
   localparam int DEN_BITS  = 10;
   localparam int DVS_BITS  = 9;
   localparam int REM_BITS  = DVS_BITS + 1;
   localparam int RES_BITS  = NUM_BITS + 1;
   localparam int STEP_BITS = $clog2(MAG_BITS);

   localparam int QUEUE_DEPTH = 2;

   // register reset values
   localparam logic [DB_BITS-1:0]  DEAD_BAND_RST   = DB_BITS'(5);
   localparam logic [POS_BITS-1:0] WIN_LOW_RST     = POS_BITS'(20);
   localparam logic [POS_BITS-1:0] WIN_HIGH_RST    = POS_BITS'(100);
   localparam logic [POS_BITS-1:0] CTRL_LOW_RST    = POS_BITS'(40);
   localparam logic [POS_BITS-1:0] CTRL_HIGH_RST   = POS_BITS'(93);
   localparam logic [POS_BITS-1:0] CENTER_RST      = POS_BITS'(64);
   localparam logic [POS_BITS-1:0] MAX_SEP_RST     = POS_BITS'(10);
   localparam logic [LIM_BITS-1:0] ERR_LIMIT_RST   = LIM_BITS'(100);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEAD_BAND,
      CSR_WIN_LOW,
      CSR_WIN_HIGH,
      CSR_CTRL_LOW,
      CSR_CTRL_HIGH,
      CSR_CENTER,
      CSR_MAX_SEP,
      CSR_ERR_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic [DB_BITS-1:0]  dead_band;
      logic [POS_BITS-1:0] deriv_window_low;
      logic [POS_BITS-1:0] deriv_window_high;
      logic [POS_BITS-1:0] control_low;
      logic [POS_BITS-1:0] control_high;
      logic [POS_BITS-1:0] center_pixel;
      logic [POS_BITS-1:0] max_separation;
      logic [LIM_BITS-1:0] error_limit;
   } cfg_type;

   // per-beat control travelling from front to back
   typedef struct packed {
      logic a_valid;   // difference of the sample's own pixel counts
      logic b_valid;   // closing difference at end of line counts
      logic eol;
   } qctl_type;

   typedef enum logic [2:0] {
      ST_TRACK,
      ST_SEP,
      ST_MAP,
      ST_PREP,
      ST_DIV,
      ST_FIX
   } back_state_type;

endpackage

`default_nettype wire

>>> design/les_if.sv
// les_req_if and les_rsp_if: valid/ready channels of the line edge steering error block
// depends on les_pkg
`timescale 1ns / 1ps
`default_nettype none

interface les_req_if import les_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   end_of_line;

   modport source (output valid, output sample, output end_of_line, input ready);
   modport sink   (input valid, input sample, input end_of_line, output ready);
endinterface

interface les_rsp_if import les_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [ERR_BITS-1:0] steer_error;
   logic                       line_seen;
   logic [POS_BITS-1:0]        rise_position;
   logic [POS_BITS-1:0]        fall_position;

   modport source (output valid, output steer_error, output line_seen,
                   output rise_position, output fall_position, input ready);
   modport sink   (input valid, input steer_error, input line_seen,
                   input rise_position, input fall_position, output ready);
endinterface

`default_nettype wire

>>> design/les_front.sv
// les_front: accepts sample beats, keeps the two-sample window and pixel count,
// and classifies each central difference (window, dead band); depends on les_pkg, les_if
`timescale 1ns / 1ps
`default_nettype none

module les_front import les_pkg::*; #(
   parameter int PIXELS      = PIXELS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   les_req_if.sink                            req_if,
   input  wire cfg_type                       cfg,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output qctl_type                           ctl,
   output logic [POS_BITS-1:0]                a_idx,
   output logic signed [SAMPLE_BITS:0]        a_diff,
   output logic [POS_BITS-1:0]                b_idx,
   output logic signed [SAMPLE_BITS:0]        b_diff
);

   localparam int CNT_BITS = $clog2(PIXELS + 1);
   localparam int DW       = SAMPLE_BITS + 1;
   localparam int CW       = ((DW > DB_BITS) ? DW : DB_BITS) + 1;

   logic [CNT_BITS-1:0]    pc_ff, pc_in;
   logic [SAMPLE_BITS-1:0] win0_ff, win0_in;
   logic [SAMPLE_BITS-1:0] win1_ff, win1_in;

   logic                   accept;
   logic                   active;
   logic [CNT_BITS-1:0]    pc_step;
   logic [SAMPLE_BITS-1:0] win1_step;
   logic signed [DW-1:0]   d1, d2;

   function automatic logic in_window(input logic [POS_BITS-1:0] idx, input cfg_type c);
      in_window = (idx >= c.deriv_window_low) && (idx <= c.deriv_window_high);
   endfunction

   function automatic logic signed [DW-1:0] dead_zone(input logic signed [DW-1:0] d,
                                                     input logic [DB_BITS-1:0] db);
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dbx;
      dx  = CW'(d);
      dbx = $signed({{(CW-DB_BITS){1'b0}}, db});
      if ((dx >= -dbx) && (dx <= dbx)) begin
         dead_zone = '0;
      end else begin
         dead_zone = d;
      end
   endfunction

   assign accept        = req_if.valid && push_ready;
   assign req_if.ready  = push_ready;
   assign push_valid    = req_if.valid;

   always_comb begin
      active    = pc_ff < CNT_BITS'(PIXELS);
      pc_step   = active ? pc_ff + CNT_BITS'(1) : pc_ff;
      win1_step = active ? win0_ff : win1_ff;

      // neighbours outside the frame read as zero, so the window starts cleared
      d1 = $signed({1'b0, req_if.sample}) - $signed({1'b0, win1_ff});
      d2 = -$signed({1'b0, win1_step});

      a_idx  = POS_BITS'(pc_ff - CNT_BITS'(1));
      b_idx  = POS_BITS'(pc_step - CNT_BITS'(1));
      a_diff = dead_zone(d1, cfg.dead_band);
      b_diff = dead_zone(d2, cfg.dead_band);

      ctl.a_valid = active && (pc_ff != '0) && in_window(a_idx, cfg);
      ctl.b_valid = req_if.end_of_line && (pc_step != '0) && in_window(b_idx, cfg);
      ctl.eol     = req_if.end_of_line;

      pc_in   = pc_ff;
      win0_in = win0_ff;
      win1_in = win1_ff;
      if (accept) begin
         if (req_if.end_of_line) begin
            pc_in   = '0;
            win0_in = '0;
            win1_in = '0;
         end else if (active) begin
            pc_in   = pc_step;
            win0_in = req_if.sample;
            win1_in = win0_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         win0_ff <= '0;
         win1_ff <= '0;
      end else begin
         pc_ff   <= pc_in;
         win0_ff <= win0_in;
         win1_ff <= win1_in;
      end
   end

endmodule

`default_nettype wire

>>> design/les_queue.sv
// les_queue: short valid/ready queue that decouples the front from the back
// depends on les_pkg
`timescale 1ns / 1ps
`default_nettype none

module les_queue import les_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> design/les_back.sv
// les_back: edge tracker, end-of-line separation check, linear mapping with a
// shift-subtract divider, saturation and the result register; depends on les_pkg, les_if
`timescale 1ns / 1ps
`default_nettype none

module les_back import les_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cfg_type                cfg,
   input  wire logic                   ent_valid,
   output logic                        ent_ready,
   input  wire qctl_type               ctl,
   input  wire logic [POS_BITS-1:0]    a_idx,
   input  wire logic [SAMPLE_BITS:0]   a_diff,
   input  wire logic [POS_BITS-1:0]    b_idx,
   input  wire logic [SAMPLE_BITS:0]   b_diff,
   les_rsp_if.source                   rsp_if
);

   localparam int DW = SAMPLE_BITS + 1;

   localparam logic [DW-1:0] HIGH_RST = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] LOW_RST  = {1'b0, {(DW-1){1'b1}}};

   typedef struct packed {
      logic [DW-1:0]       hd;
      logic [DW-1:0]       ld;
      logic [POS_BITS-1:0] hp;
      logic [POS_BITS-1:0] lp;
   } trk_type;

   back_state_type state_ff, state_in;

   trk_type trk_ff, trk_in;
   logic signed [ERR_BITS-1:0] held_ff, held_in;
   logic                       seen_ff, seen_in;
   logic signed [ERR_BITS-1:0] omin_ff, omin_in;
   logic signed [NUM_BITS-1:0] num_ff, num_in;
   logic signed [DEN_BITS-1:0] den_ff, den_in;
   logic [MAG_BITS-1:0]        mag_ff, mag_in;
   logic [DVS_BITS-1:0]        dvs_ff, dvs_in;
   logic [REM_BITS-1:0]        rem_ff, rem_in;
   logic                       qneg_ff, qneg_in;
   logic [STEP_BITS-1:0]       step_ff, step_in;

   logic                       out_valid_ff, out_valid_in;
   logic signed [ERR_BITS-1:0] out_err_ff, out_err_in;
   logic                       out_seen_ff, out_seen_in;
   logic [POS_BITS-1:0]        out_rise_ff, out_rise_in;
   logic [POS_BITS-1:0]        out_fall_ff, out_fall_in;

   trk_type                    trk_a, trk_b;
   logic signed [POS_BITS:0]   sep;
   logic                       left;
   logic [POS_BITS-1:0]        x, base, dtop, dbot;
   logic signed [POS_BITS:0]   xd;
   logic signed [ERR_BITS-1:0] kk;
   logic signed [NUM_BITS-1:0] prod;
   logic signed [NUM_BITS-1:0] absn;
   logic signed [DEN_BITS-1:0] absd;
   logic [REM_BITS-1:0]        trial;
   logic                       qbit;
   logic signed [NUM_BITS-1:0] qs;
   logic signed [RES_BITS-1:0] res;
   logic signed [ERR_BITS-1:0] sat;
   logic                       out_free;

   // a pixel updates the largest difference, or failing that the smallest
   function automatic trk_type track_step(input trk_type t, input logic v,
                                          input logic [POS_BITS-1:0] idx,
                                          input logic [DW-1:0] d);
      trk_type r;
      r = t;
      if (v) begin
         if ($signed(t.hd) < $signed(d)) begin
            r.hd = d;
            r.hp = idx;
         end else if ($signed(t.ld) > $signed(d)) begin
            r.ld = d;
            r.lp = idx;
         end
      end
      track_step = r;
   endfunction

   assign out_free             = !out_valid_ff || rsp_if.ready;
   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.steer_error   = out_err_ff;
   assign rsp_if.line_seen     = out_seen_ff;
   assign rsp_if.rise_position = out_rise_ff;
   assign rsp_if.fall_position = out_fall_ff;

   always_comb begin
      state_in     = state_ff;
      trk_in       = trk_ff;
      held_in      = held_ff;
      seen_in      = seen_ff;
      omin_in      = omin_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      mag_in       = mag_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      qneg_in      = qneg_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_err_in   = out_err_ff;
      out_seen_in  = out_seen_ff;
      out_rise_in  = out_rise_ff;
      out_fall_in  = out_fall_ff;
      ent_ready    = 1'b0;

      trk_a = track_step(trk_ff, ctl.a_valid, a_idx, a_diff);
      trk_b = track_step(trk_a, ctl.b_valid, b_idx, b_diff);

      sep = $signed({1'b0, trk_ff.hp}) - $signed({1'b0, trk_ff.lp});

      left = trk_ff.hp >= cfg.center_pixel;
      x    = left ? trk_ff.lp : trk_ff.hp;
      base = left ? cfg.center_pixel : cfg.control_high;
      dtop = left ? cfg.control_low : cfg.center_pixel;
      dbot = left ? cfg.center_pixel : cfg.control_high;
      xd   = $signed({1'b0, x}) - $signed({1'b0, base});
      kk   = ERR_BITS'(1) - $signed({1'b0, cfg.error_limit});
      prod = xd * kk;

      absn = num_ff[NUM_BITS-1] ? -num_ff : num_ff;
      absd = den_ff[DEN_BITS-1] ? -den_ff : den_ff;

      trial = {rem_ff[REM_BITS-2:0], mag_ff[MAG_BITS-1]};
      qbit  = trial >= {1'b0, dvs_ff};

      qs  = $signed({1'b0, mag_ff});
      res = qneg_ff ? -RES_BITS'(qs) : RES_BITS'(qs);
      res = res + RES_BITS'(omin_ff);
      if (res > RES_BITS'(ERR_MAX)) begin
         sat = ERR_BITS'(ERR_MAX);
      end else if (res < RES_BITS'(ERR_MIN)) begin
         sat = ERR_BITS'(ERR_MIN);
      end else begin
         sat = res[ERR_BITS-1:0];
      end

      unique case (state_ff)
         ST_TRACK: begin
            ent_ready = 1'b1;
            if (ent_valid) begin
               trk_in = trk_b;
               if (ctl.eol) begin
                  trk_in.hd = HIGH_RST;
                  trk_in.ld = LOW_RST;
                  state_in  = ST_SEP;
               end
            end
         end
         ST_SEP: begin
            // edges too far apart: no line, and the rise position is cleared
            if (sep > $signed({1'b0, cfg.max_separation})) begin
               trk_in.hp = '0;
            end
            state_in = ST_MAP;
         end
         ST_MAP: begin
            seen_in = !((trk_ff.hp <= cfg.control_low) || (trk_ff.hp >= cfg.control_high));
            omin_in = left ? '0 : $signed({1'b0, cfg.error_limit});
            num_in  = prod;
            den_in  = $signed({2'b00, dtop}) - $signed({2'b00, dbot}) + DEN_BITS'(1);
            state_in = seen_in ? ST_PREP : ST_FIX;
         end
         ST_PREP: begin
            if (den_ff == '0) begin
               mag_in   = '0;
               qneg_in  = 1'b0;
               state_in = ST_FIX;
            end else begin
               mag_in   = absn[MAG_BITS-1:0];
               dvs_in   = absd[DVS_BITS-1:0];
               qneg_in  = num_ff[NUM_BITS-1] ^ den_ff[DEN_BITS-1];
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle, shifted into the dividend register
            rem_in  = qbit ? trial - {1'b0, dvs_ff} : trial;
            mag_in  = {mag_ff[MAG_BITS-2:0], qbit};
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(MAG_BITS - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_err_in   = seen_ff ? sat : held_ff;
               out_seen_in  = seen_ff;
               out_rise_in  = trk_ff.hp;
               out_fall_in  = trk_ff.lp;
               if (seen_ff) begin
                  held_in = sat;
               end
               state_in = ST_TRACK;
            end
         end
         default: state_in = ST_TRACK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TRACK;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trk_ff.hd    <= HIGH_RST;
         trk_ff.ld    <= LOW_RST;
         trk_ff.hp    <= '0;
         trk_ff.lp    <= '0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         trk_ff       <= trk_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seen_ff     <= seen_in;
      omin_ff     <= omin_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      mag_ff      <= mag_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      qneg_ff     <= qneg_in;
      step_ff     <= step_in;
      out_err_ff  <= out_err_in;
      out_seen_ff <= out_seen_in;
      out_rise_ff <= out_rise_in;
      out_fall_ff <= out_fall_in;
   end

endmodule

`default_nettype wire

>>> design/line_edge_steering_error.sv
// line_edge_steering_error: top level with configuration registers, front, queue and back
// depends on les_pkg, les_if, les_front, les_queue, les_back
//
// Takes one pixel beat per cycle on req_if while the queue has room; end_of_line on a
// beat closes the line and yields one result beat on rsp_if. At end of line the back
// runs the separation check and then the mapping setup. When a new error is mapped it
// loads the divider and then runs the shift-subtract divider; the divider is skipped
// when the divisor is zero. It then loads the result register, which waits while an
// earlier result beat is still held. Meanwhile the two-entry queue takes the next beats
// and the front stalls once it is full. The user must write registers through
// csr_we/csr_index/csr_wdata only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module line_edge_steering_error import les_pkg::*; #(
   parameter int PIXELS      = PIXELS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   les_req_if.sink                       req_if,
   les_rsp_if.source                     rsp_if,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int DW = SAMPLE_BITS + 1;
   localparam int QW = $bits(qctl_type) + 2 * (POS_BITS + DW);

   cfg_type cfg_ff, cfg_in;

   logic                f_valid, f_ready;
   qctl_type            f_ctl, b_ctl;
   logic [POS_BITS-1:0] f_a_idx, f_b_idx, b_a_idx, b_b_idx;
   logic [DW-1:0]       f_a_diff, f_b_diff, b_a_diff, b_b_diff;
   logic [QW-1:0]       q_in, q_out;
   logic                q_valid, q_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEAD_BAND: cfg_in.dead_band         = csr_wdata[DB_BITS-1:0];
            CSR_WIN_LOW:   cfg_in.deriv_window_low  = csr_wdata[POS_BITS-1:0];
            CSR_WIN_HIGH:  cfg_in.deriv_window_high = csr_wdata[POS_BITS-1:0];
            CSR_CTRL_LOW:  cfg_in.control_low       = csr_wdata[POS_BITS-1:0];
            CSR_CTRL_HIGH: cfg_in.control_high      = csr_wdata[POS_BITS-1:0];
            CSR_CENTER:    cfg_in.center_pixel      = csr_wdata[POS_BITS-1:0];
            CSR_MAX_SEP:   cfg_in.max_separation    = csr_wdata[POS_BITS-1:0];
            CSR_ERR_LIMIT: cfg_in.error_limit       = csr_wdata[LIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_band         <= DEAD_BAND_RST;
         cfg_ff.deriv_window_low  <= WIN_LOW_RST;
         cfg_ff.deriv_window_high <= WIN_HIGH_RST;
         cfg_ff.control_low       <= CTRL_LOW_RST;
         cfg_ff.control_high      <= CTRL_HIGH_RST;
         cfg_ff.center_pixel      <= CENTER_RST;
         cfg_ff.max_separation    <= MAX_SEP_RST;
         cfg_ff.error_limit       <= ERR_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   les_front #(
      .PIXELS      (PIXELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg_ff),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .ctl        (f_ctl),
      .a_idx      (f_a_idx),
      .a_diff     (f_a_diff),
      .b_idx      (f_b_idx),
      .b_diff     (f_b_diff)
   );

   assign q_in = {f_ctl, f_a_idx, f_a_diff, f_b_idx, f_b_diff};

   les_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (q_in),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_out)
   );

   assign {b_ctl, b_a_idx, b_a_diff, b_b_idx, b_b_diff} = q_out;

   les_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .ent_valid (q_valid),
      .ent_ready (q_ready),
      .ctl       (b_ctl),
      .a_idx     (b_a_idx),
      .a_diff    (b_a_diff),
      .b_idx     (b_b_idx),
      .b_diff    (b_b_diff),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire
